// ===== rtl/core/cle_pkg.sv =====
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types and constants for the circular list engine: field widths,
// operation and status codes, and the sequencer states.
// ----------------------------------------------------------------------------
package cle_pkg;

  localparam int OP_W     = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 7;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_INSERT     = 3'd4,
    OP_DELETE     = 3'd5,
    OP_DUMP       = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_INS,
    S_LINK,
    S_DEL,
    S_DUMP_RD,
    S_DUMP_LD,
    S_RESP
  } state_t;

endpackage

// ===== rtl/core/cle_cmd_if.sv =====
// ----------------------------------------------------------------------------
// cle_cmd_if
// Command channel of the circular list engine: one word per operation.
// ----------------------------------------------------------------------------
interface cle_cmd_if;
  import cle_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           op;
  logic signed [VALUE_W-1:0] value;
  logic [POS_W-1:0]          position;

  modport source (output valid, op, value, position, input ready);
  modport sink   (input valid, op, value, position, output ready);

endinterface

// ===== rtl/core/cle_rsp_if.sv =====
// ----------------------------------------------------------------------------
// cle_rsp_if
// Response channel of the circular list engine: one or more words per
// operation, the final one marked by last.
// ----------------------------------------------------------------------------
interface cle_rsp_if;
  import cle_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic signed [VALUE_W-1:0] element;
  logic [LEN_W-1:0]          length;
  logic                      last;

  modport source (output valid, status, element, length, last, input ready);
  modport sink   (input valid, status, element, length, last, output ready);

endinterface

// ===== rtl/core/circular_list_engine_core.sv =====
// ----------------------------------------------------------------------------
// circular_list_engine_core
// Bounded circular singly linked list of signed 32-bit values, kept in a
// slot store with one link per slot. Push, pop, positional insert and
// delete, and dump, all driven by a small sequencer around one memory read
// port that walks the ring one link per cycle.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake          word contents
//   -------  ---  -----------------  ---------------------------------------
//   cmd      in   valid/ready        op, value, position
//   rsp      out  valid/ready        status, element, length, last
//
// Sequencing: a command is taken only in idle. An operation that needs a
// predecessor walks the ring from the head, one link per cycle, which
// dominates its latency. Inserts also scan the free map for the lowest
// free slot, one slot per cycle, in parallel with the walk. A dump reads
// each element in S_DUMP_RD and loads it into the output register in
// S_DUMP_LD. Reset clears the free map, head, count and control; the
// stores are not cleared. A stalled response stalls the sequencer only
// when it needs to load the next response word; a new command can be
// taken while a finished word still waits in the output register.
// ----------------------------------------------------------------------------
module circular_list_engine_core #(
  parameter int DEPTH = 32
) (
  input logic        clk,
  input logic        rst,
  cle_cmd_if.sink    cmd,
  cle_rsp_if.source  rsp
);
  import cle_pkg::*;

  localparam int SW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  // Sequencer state.
  state_t state, state_next;

  // Slot stores: values and next-slot links. Read through one registered
  // port at a shared address, written through one port each.
  logic [VALUE_W-1:0] value_store [DEPTH];
  logic [SW-1:0]      link_store  [DEPTH];
  logic [VALUE_W-1:0] value_rd;
  logic [SW-1:0]      link_rd;
  logic [SW-1:0]      rd_addr;
  logic               link_we;
  logic [SW-1:0]      link_wa;
  logic [SW-1:0]      link_wd;
  logic               value_we;

  // List state.
  logic [DEPTH-1:0]   slot_free;
  logic [SW-1:0]      head_slot;
  logic [CW-1:0]      element_count;

  // Per-operation working registers.
  logic [SW-1:0]      cur;
  logic [SW-1:0]      pred;
  logic [SW-1:0]      steps;
  logic               front;
  logic               deleting;
  logic [VALUE_W-1:0] new_value;
  status_t            status_q;

  // Free-slot scanner.
  logic [SW-1:0]      scan;
  logic               scan_done;
  logic               scan_run;

  // Output register.
  logic               rsp_valid_q;
  status_t            rsp_status_q;
  logic [VALUE_W-1:0] rsp_element_q;
  logic [LEN_W-1:0]   rsp_length_q;
  logic               rsp_last_q;
  logic               out_free;
  logic               rsp_load;

  // Command decode.
  logic               accept;
  logic [7:0]         cnt8;
  logic [7:0]         pos8;
  logic [7:0]         dec_p;
  logic [7:0]         dec_steps8;
  status_t            dec_status;
  logic               dec_walk;
  logic               dec_ins_empty;
  logic               dec_del_one;
  logic               dec_delete;
  logic               dec_dump;

  assign cmd.ready  = (state == S_IDLE) && !rst;
  assign accept     = cmd.valid && cmd.ready;
  assign out_free   = !rsp_valid_q || rsp.ready;
  // A new response word enters the output register in this cycle.
  assign rsp_load   = out_free && (state == S_DUMP_LD || state == S_RESP);

  assign rsp.valid   = rsp_valid_q;
  assign rsp.status  = rsp_status_q;
  assign rsp.element = rsp_element_q;
  assign rsp.length  = rsp_length_q;
  assign rsp.last    = rsp_last_q;

  assign cnt8 = 8'(element_count);
  assign pos8 = 8'(cmd.position);

  // Work out what the command needs. The position check comes before the
  // full check for inserts; pushes carry an implied position that is always
  // in range. For both push front and push back the predecessor is the tail.
  always_comb begin
    dec_status    = ST_OK;
    dec_walk      = 1'b0;
    dec_ins_empty = 1'b0;
    dec_del_one   = 1'b0;
    dec_delete    = 1'b0;
    dec_dump      = 1'b0;
    dec_p         = 8'd1;
    case (op_t'(cmd.op))
      OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
        if (op_t'(cmd.op) == OP_PUSH_BACK) begin
          dec_p = cnt8 + 8'd1;
        end else if (op_t'(cmd.op) == OP_INSERT) begin
          dec_p = pos8;
        end
        if (op_t'(cmd.op) == OP_INSERT && (pos8 == 8'd0 || pos8 > cnt8 + 8'd1)) begin
          dec_status = ST_RANGE;
        end else if (element_count == FULL_COUNT) begin
          dec_status = ST_FULL;
        end else if (element_count == '0) begin
          dec_ins_empty = 1'b1;
        end else begin
          dec_walk = 1'b1;
        end
      end
      OP_POP_FRONT, OP_POP_BACK, OP_DELETE: begin
        dec_delete = 1'b1;
        if (op_t'(cmd.op) == OP_POP_BACK) begin
          dec_p = cnt8;
        end else if (op_t'(cmd.op) == OP_DELETE) begin
          dec_p = pos8;
        end
        if (element_count == '0) begin
          dec_status = ST_EMPTY;
        end else if (dec_p == 8'd0 || dec_p > cnt8) begin
          dec_status = ST_RANGE;
        end else if (element_count == CW'(1)) begin
          dec_del_one = 1'b1;
        end else begin
          dec_walk = 1'b1;
        end
      end
      OP_DUMP: begin
        if (element_count == '0) begin
          dec_status = ST_EMPTY;
        end else begin
          dec_dump = 1'b1;
        end
      end
      default: begin
      end
    endcase
    // Links to follow from the head to reach the predecessor; for a dump,
    // the number of words left after the first.
    dec_steps8 = (dec_p == 8'd1) ? (cnt8 - 8'd1) : (dec_p - 8'd2);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (dec_walk) begin
            state_next = S_WALK;
          end else if (dec_ins_empty) begin
            state_next = S_INS;
          end else if (dec_dump) begin
            state_next = S_DUMP_RD;
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_WALK: begin
        if (steps == '0) begin
          state_next = deleting ? S_DEL : S_INS;
        end
      end
      S_INS: begin
        if (scan_done) begin
          state_next = (element_count == '0) ? S_RESP : S_LINK;
        end
      end
      S_LINK:    state_next = S_RESP;
      S_DEL:     state_next = S_RESP;
      S_DUMP_RD: state_next = S_DUMP_LD;
      S_DUMP_LD: begin
        if (out_free) begin
          state_next = (steps == '0) ? S_IDLE : S_DUMP_RD;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory port control. During the walk the read address follows the link
  // just read, so one link is taken per cycle; when the walk ends the port
  // has already fetched the link of the predecessor's successor.
  always_comb begin
    rd_addr  = cur;
    link_we  = 1'b0;
    link_wa  = pred;
    link_wd  = scan;
    value_we = 1'b0;
    case (state)
      S_IDLE: rd_addr = head_slot;
      S_WALK: rd_addr = link_rd;
      S_INS: begin
        // New slot links to the old successor, or to itself in an empty list.
        link_we  = scan_done;
        value_we = scan_done;
        link_wa  = scan;
        link_wd  = (element_count == '0) ? scan : cur;
      end
      S_LINK: begin
        link_we = 1'b1;
      end
      S_DEL: begin
        // Unlink the victim: the predecessor takes over its link.
        link_we = 1'b1;
        link_wd = link_rd;
      end
      default: begin
      end
    endcase
  end

  assign scan_run = (state == S_INS) || (state == S_WALK && !deleting);

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_store[link_wa] <= link_wd;
    end
    if (value_we) begin
      value_store[scan] <= new_value;
    end
    link_rd  <= link_store[rd_addr];
    value_rd <= value_store[rd_addr];
  end

  // Control and list state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      slot_free     <= '1;
      head_slot     <= '0;
      element_count <= '0;
      scan_done     <= 1'b0;
      rsp_valid_q   <= 1'b0;
    end else begin
      state <= state_next;

      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end

      if (scan_run && !scan_done) begin
        if (slot_free[scan]) begin
          scan_done <= 1'b1;
        end else begin
          scan <= scan + SW'(1);
        end
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            new_value <= cmd.value;
            front     <= (dec_p == 8'd1);
            deleting  <= dec_delete;
            status_q  <= dec_status;
            steps     <= dec_steps8[SW-1:0];
            cur       <= head_slot;
            scan      <= '0;
            scan_done <= 1'b0;
            if (dec_del_one) begin
              // Last element goes; the head keeps its stale value.
              slot_free[head_slot] <= 1'b1;
              element_count        <= '0;
            end
          end
        end
        S_WALK: begin
          cur <= link_rd;
          if (steps == '0) begin
            pred <= cur;
          end else begin
            steps <= steps - SW'(1);
          end
        end
        S_INS: begin
          if (scan_done) begin
            slot_free[scan] <= 1'b0;
            element_count   <= element_count + CW'(1);
            if (front || element_count == '0) begin
              head_slot <= scan;
            end
          end
        end
        S_DEL: begin
          slot_free[cur] <= 1'b1;
          element_count  <= element_count - CW'(1);
          if (front) begin
            head_slot <= link_rd;
          end
        end
        S_DUMP_LD: begin
          if (out_free) begin
            rsp_status_q  <= ST_OK;
            rsp_element_q <= value_rd;
            rsp_length_q  <= LEN_W'(element_count);
            rsp_last_q    <= (steps == '0);
            cur           <= link_rd;
            steps         <= steps - SW'(1);
          end
        end
        S_RESP: begin
          if (out_free) begin
            rsp_status_q  <= status_q;
            rsp_element_q <= '0;
            rsp_length_q  <= LEN_W'(element_count);
            rsp_last_q    <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
